// ===== rtl/core/swmp_pkg.sv =====
// shared types and constants of the square wave melody player
package swmp_pkg;

    // default values of the top level parameters
    localparam int DEF_MAX_NOTES       = 64;
    localparam int DEF_CLOCK_HZ        = 2000000;
    localparam int DEF_TICKS_PER_COUNT = 1024;

    // field widths
    localparam int TEMPO_W    = 10;
    localparam int COUNT_W    = 7;
    localparam int FREQ_W     = 16;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_COUNT = 2'd1;

    // configuration reset values
    localparam logic [TEMPO_W-1:0] TEMPO_RST      = 10'd120;
    localparam logic [COUNT_W-1:0] NOTE_COUNT_RST = 7'd64;

    // milliseconds of a whole note at one beat per minute
    localparam int WHOLE_NOTE_MS = 240000;
    localparam int WHOLE_NOTE_W  = $clog2(WHOLE_NOTE_MS + 1);

    // item action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // tick sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_HP,
        S_TEMPO,
        S_MAG,
        S_UPDATE
    } t_state;

endpackage

// ===== rtl/core/swmp_in_if.sv =====
// input channel of the melody player: tick and note load items
interface swmp_in_if
    import swmp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic [FREQ_W-1:0]        entry_freq;
    logic signed [LEN_W-1:0]  entry_length;

    modport source (
        output valid, action, entry_index, entry_freq, entry_length,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_freq, entry_length,
        output ready
    );
endinterface

// ===== rtl/core/swmp_out_if.sv =====
// output channel of the melody player: one result item per input item
interface swmp_out_if
    import swmp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             buzzer_level;
    logic [IDX_W-1:0] note_index;
    logic             note_advanced;

    modport source (
        output valid, buzzer_level, note_index, note_advanced,
        input  ready
    );
    modport sink (
        input  valid, buzzer_level, note_index, note_advanced,
        output ready
    );
endinterface

// ===== rtl/core/swmp_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module swmp_div
    import swmp_pkg::*;
#(
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // shift in the next dividend bit and trial subtract
    always_comb begin
        w_sh   = {r_rem, r_quo[DW-1]};
        w_diff = w_sh - {1'b0, r_dvs};
        w_ge   = (w_sh >= {1'b0, r_dvs});
    end

    // control: busy flag, step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/square_wave_melody_player.sv =====
// square wave melody player: note table memory, tick sequencer and tone/length counters
//
//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+----------------------------------------------------
//  i_note     | in  | valid / ready  | action, entry_index, entry_freq, entry_length
//  o_res      | out | valid / ready  | buzzer_level, note_index, note_advanced
//  i_cfg_*    | in  | write enable   | i_cfg_idx (0 tempo, 1 note count), i_cfg_wdata
//
// a load item writes the note memory and yields its result in the next cycle
// a tick item takes a memory read, then three passes of the shared bit-serial divider
// (DW = quotient width, one bit a cycle) for the half period, the beat length and the
// note length, then the counter update; one item at a time, and a new item is taken
// only when the output register is empty or its result is being taken
// reset is synchronous and active low; the note memory is not cleared
module square_wave_melody_player
    import swmp_pkg::*;
#(
    parameter int MAX_NOTES       = DEF_MAX_NOTES,
    parameter int CLOCK_HZ        = DEF_CLOCK_HZ,
    parameter int TICKS_PER_COUNT = DEF_TICKS_PER_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    swmp_in_if.sink               i_note,
    swmp_out_if.source            o_res
);
    localparam int AW    = $clog2(MAX_NOTES);
    localparam int LW_N  = $clog2(MAX_NOTES + 1);
    localparam int LW    = (LW_N > COUNT_W) ? LW_N : COUNT_W;
    localparam int DW_HZ = $clog2(CLOCK_HZ + 1);
    localparam int DW    = (DW_HZ > WHOLE_NOTE_W) ? DW_HZ : WHOLE_NOTE_W;
    localparam int PW    = $clog2(TICKS_PER_COUNT + 1);
    localparam int XW    = WHOLE_NOTE_W + 2;
    localparam int MW    = FREQ_W + LEN_W;

    // configuration registers
    logic [TEMPO_W-1:0] r_tempo;
    logic [COUNT_W-1:0] r_count;

    // note memory: frequency over length divisor
    logic [MW-1:0]      r_mem [MAX_NOTES];
    logic [MW-1:0]      r_mem_q;

    // sequencer and player state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_cur, n_cur;
    logic [15:0]        r_tone, n_tone;
    logic [15:0]        r_hp;
    logic [PW-1:0]      r_pre, n_pre;
    logic [15:0]        r_lc, n_lc;
    logic [15:0]        r_limit;
    logic               r_level, n_level;
    logic               n_adv;

    // output register
    logic               r_ovalid;
    logic               r_obuz;
    logic [IDX_W-1:0]   r_oidx;
    logic               r_oadv;

    // handshake and decode
    logic               w_in_ready;
    logic               w_in_acc;
    logic               w_tick_acc;
    logic               w_load_acc;
    logic               w_out_taken;

    // divider hookup
    logic               w_div_start;
    logic [DW-1:0]      w_div_dvd;
    logic [DW-1:0]      w_div_dvs;
    logic               w_div_done;
    logic [DW-1:0]      w_div_q;

    // current entry fields
    logic [FREQ_W-1:0]  w_freq;
    logic [LEN_W-1:0]   w_len;
    logic               w_dotted;
    logic [LEN_W-1:0]   w_mag;
    logic               w_len_inf;

    // note length arithmetic
    logic [XW-1:0]      w_q2;
    logic [XW-1:0]      w_x;
    logic [XW-1:0]      w_lim;
    logic [15:0]        w_lim_sat;
    logic [15:0]        w_hp_sat;

    // update arithmetic
    logic [15:0]        w_tone1;
    logic [PW-1:0]      w_pre1;
    logic [15:0]        w_lc1;
    logic [LW-1:0]      w_wrap;
    logic [LW-1:0]      w_next_note;

    assign w_in_acc    = i_note.valid && w_in_ready;
    assign w_tick_acc  = w_in_acc && (i_note.action == ACT_TICK);
    assign w_load_acc  = w_in_acc && (i_note.action == ACT_LOAD);
    assign w_out_taken = r_ovalid && o_res.ready;

    assign w_freq    = r_mem_q[MW-1:LEN_W];
    assign w_len     = r_mem_q[LEN_W-1:0];
    assign w_dotted  = w_len[LEN_W-1];
    assign w_mag     = w_dotted ? (LEN_W'(0) - w_len) : w_len;
    assign w_len_inf = (w_mag == '0) || (r_tempo == '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo <= TEMPO_RST;
            r_count <= NOTE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMPO:      r_tempo <= i_cfg_wdata[TEMPO_W-1:0];
                CFG_NOTE_COUNT: r_count <= i_cfg_wdata[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // note memory: load writes, tick reads the current note
    always_ff @(posedge i_clk) begin
        if (w_load_acc && (LW'(i_note.entry_index) < LW'(MAX_NOTES))) begin
            r_mem[AW'(i_note.entry_index)] <= {i_note.entry_freq, i_note.entry_length};
        end
        if (w_tick_acc) begin
            r_mem_q <= r_mem[r_cur];
        end
    end

    // shared divider
    swmp_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_tick_acc) n_state = S_READ;
            S_READ:   n_state = S_HP;
            S_HP:     if (w_div_done) n_state = S_TEMPO;
            S_TEMPO:  if (w_div_done) n_state = S_MAG;
            S_MAG:    if (w_div_done) n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: input ready and divider operands
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_div_dvd   = DW'(CLOCK_HZ);
        w_div_dvs   = DW'({w_freq, 1'b0});
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = !r_ovalid || o_res.ready;
            end
            S_READ: begin
                w_div_start = 1'b1;
            end
            S_HP: begin
                w_div_start = w_div_done;
                w_div_dvd   = DW'(WHOLE_NOTE_MS);
                w_div_dvs   = DW'(r_tempo);
            end
            S_TEMPO: begin
                w_div_start = w_div_done;
                w_div_dvd   = w_div_q;
                w_div_dvs   = DW'(w_mag);
            end
            default: ;
        endcase
    end

    // half period and note length from the divider quotients
    always_comb begin
        w_hp_sat  = (|w_div_q[DW-1:16]) ? 16'hFFFF : w_div_q[15:0];
        w_q2      = XW'(w_div_q) << 1;
        w_x       = w_dotted ? (w_q2 + XW'(w_div_q)) : w_q2;
        w_lim     = w_x - (w_x >> 5) + (w_x >> 7);
        w_lim_sat = (|w_lim[XW-1:16]) ? 16'hFFFF : w_lim[15:0];
    end

    // tone and length counter update for one tick
    always_comb begin
        w_tone1     = r_tone + 16'd1;
        w_pre1      = r_pre + 1'b1;
        w_lc1       = r_lc + 16'd1;
        w_next_note = LW'(r_cur) + 1'b1;
        if (r_count == '0) begin
            w_wrap = LW'(1);
        end else if (LW'(r_count) > LW'(MAX_NOTES)) begin
            w_wrap = LW'(MAX_NOTES);
        end else begin
            w_wrap = LW'(r_count);
        end

        n_level = r_level;
        n_tone  = w_tone1;
        n_pre   = w_pre1;
        n_lc    = r_lc;
        n_cur   = r_cur;
        n_adv   = 1'b0;

        // square wave, rests hold the output low
        if (w_freq == '0) begin
            n_level = 1'b0;
            n_tone  = '0;
        end else if (w_tone1 >= r_hp) begin
            n_tone  = '0;
            n_level = !r_level;
        end

        // prescaler and note length
        if (w_pre1 >= PW'(TICKS_PER_COUNT)) begin
            n_pre = '0;
            if (w_lc1 >= r_limit) begin
                n_lc   = '0;
                n_tone = '0;
                n_adv  = 1'b1;
                n_cur  = (w_next_note >= w_wrap) ? '0 : AW'(w_next_note);
            end else begin
                n_lc = w_lc1;
            end
        end
    end

    // sequencer and player registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_tone  <= '0;
            r_hp    <= '0;
            r_pre   <= '0;
            r_lc    <= '0;
            r_limit <= '0;
            r_level <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_HP && w_div_done) begin
                r_hp <= (w_freq == '0) ? '0 : w_hp_sat;
            end
            if (r_state == S_MAG && w_div_done) begin
                r_limit <= w_len_inf ? 16'hFFFF : w_lim_sat;
            end
            if (r_state == S_UPDATE) begin
                r_cur   <= n_cur;
                r_tone  <= n_tone;
                r_pre   <= n_pre;
                r_lc    <= n_lc;
                r_level <= n_level;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_acc || r_state == S_UPDATE) begin
            r_ovalid <= 1'b1;
        end else if (w_out_taken) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load_acc) begin
            r_obuz <= r_level;
            r_oidx <= IDX_W'(r_cur);
            r_oadv <= 1'b0;
        end else if (r_state == S_UPDATE) begin
            r_obuz <= n_level;
            r_oidx <= IDX_W'(n_cur);
            r_oadv <= n_adv;
        end
    end

    assign i_note.ready        = w_in_ready;
    assign o_res.valid         = r_ovalid;
    assign o_res.buzzer_level  = r_obuz;
    assign o_res.note_index    = r_oidx;
    assign o_res.note_advanced = r_oadv;

endmodule
